// File: sv/pva_pkg.sv
`timescale 1ns / 1ps

package pva_pkg;

  typedef enum logic [1:0] {
    KIND_NOTE_ON  = 2'd0,
    KIND_NOTE_OFF = 2'd1,
    KIND_FINISHED = 2'd2
  } pva_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } pva_state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [2:0]  voice_index;
    logic [31:0] now;
  } pva_in_t;

  typedef struct packed {
    logic [2:0] assigned_voice;
    logic       start_attack;
    logic       was_stolen;
    logic [7:0] release_mask;
    logic [6:0] out_note;
    logic [6:0] out_velocity;
  } pva_out_t;

  // one voice slot as seen by the compare unit
  typedef struct packed {
    logic        active;
    logic [6:0]  note;
    logic [31:0] stamp;
  } pva_entry_t;

  // running steal candidate
  typedef struct packed {
    logic        have_active;
    logic [31:0] best;
  } pva_track_t;

  typedef struct packed {
    logic is_free;
    logic better;
    logic hit;
  } pva_dec_t;

endpackage

// File: sv/pva_cmp.sv
`timescale 1ns / 1ps

module pva_cmp (
  input  pva_pkg::pva_entry_t entry_i,
  input  pva_pkg::pva_track_t track_i,
  input  logic [6:0]          note_i,
  output pva_pkg::pva_dec_t   dec_o
);
  import pva_pkg::*;

  always_comb begin
    dec_o.is_free = !entry_i.active;
    dec_o.better  = entry_i.active &&
                    (!track_i.have_active || (entry_i.stamp < track_i.best));
    dec_o.hit     = entry_i.active && (entry_i.note == note_i);
  end

endmodule

// File: sv/poly_voice_allocator.sv
// Polyphonic voice allocator with oldest-voice stealing.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one event per
// transaction: note on, note off or voice finished. Output channel
// (out_valid_o / out_stall_i / out_data_o) returns exactly one result per
// event, in order.
// Note on and note off walk the voice table one voice per cycle through a
// single shared compare unit (free check, 32-bit stamp compare, note match),
// then commit in the ST_FINISH step once the output register is free.
// Voice finished and unused kinds skip the walk and go straight to commit.
// The next event is accepted the cycle after the previous one reaches
// the output register.
// The output register holds a finished result while out_stall_i is high;
// the block may accept and process one more event meanwhile, and waits in
// its commit step until the output register frees up.
// Reset clears all active bits and the control state; note and stamp
// storage is only read for active voices and needs no clearing.
`timescale 1ns / 1ps

module poly_voice_allocator #(
  parameter int VOICES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pva_pkg::pva_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pva_pkg::pva_out_t out_data_o
);
  import pva_pkg::*;

  localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(VOICES - 1);

  pva_state_e state_q, state_d;

  logic [VOICES-1:0] active_q;
  logic [6:0]        note_q  [VOICES];
  logic [31:0]       stamp_q [VOICES];

  pva_in_t     item_q;
  logic [IW-1:0] idx_q;
  pva_track_t  track_q;
  logic        have_free_q;
  logic [IW-1:0] free_v_q, steal_v_q;
  logic [7:0]  mask_q;

  logic     out_valid_q;
  pva_out_t out_q;

  logic       in_take, out_free, commit;
  pva_entry_t entry;
  pva_dec_t   dec;
  logic [IW-1:0] chosen;
  logic       fin_ok;
  pva_out_t   res;

  assign entry.active = active_q[idx_q];
  assign entry.note   = note_q[idx_q];
  assign entry.stamp  = stamp_q[idx_q];

  pva_cmp u_cmp (
    .entry_i (entry),
    .track_i (track_q),
    .note_i  (item_q.note),
    .dec_o   (dec)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign chosen   = have_free_q ? free_v_q : steal_v_q;
  assign fin_ok   = ({29'd0, item_q.voice_index} < 32'(VOICES));

  always_comb begin
    res = '0;
    unique case (item_q.kind)
      KIND_NOTE_ON: begin
        res.assigned_voice = 3'(chosen);
        res.start_attack   = 1'b1;
        res.was_stolen     = !have_free_q;
        res.out_note       = item_q.note;
        res.out_velocity   = item_q.velocity;
      end
      KIND_NOTE_OFF: res.release_mask = mask_q;
      default:       res = '0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    in_take    = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        in_take    = in_valid_i;
        if (in_valid_i) begin
          if ((in_data_i.kind == KIND_NOTE_ON) || (in_data_i.kind == KIND_NOTE_OFF)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (idx_q == LastIdx) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_valid_q <= 1'b1;
        if (item_q.kind == KIND_NOTE_ON) begin
          active_q[chosen] <= 1'b1;
        end else if ((item_q.kind == KIND_FINISHED) && fin_ok) begin
          active_q[IW'(item_q.voice_index)] <= 1'b0;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q      <= in_data_i;
      idx_q       <= '0;
      track_q     <= '0;
      have_free_q <= 1'b0;
      free_v_q    <= '0;
      steal_v_q   <= '0;
      mask_q      <= '0;
    end
    if (state_q == ST_SCAN) begin
      idx_q <= idx_q + 1'b1;
      if (dec.is_free) begin
        have_free_q <= 1'b1;
        free_v_q    <= idx_q;
      end else if (dec.better) begin
        track_q.have_active <= 1'b1;
        track_q.best        <= entry.stamp;
        steal_v_q           <= idx_q;
      end
      if (dec.hit) begin
        mask_q <= mask_q | (8'd1 << idx_q);
      end
    end
    if (commit) begin
      out_q <= res;
      if (item_q.kind == KIND_NOTE_ON) begin
        note_q[chosen]  <= item_q.note;
        stamp_q[chosen] <= item_q.now;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/pva_checker.sv
`timescale 1ns / 1ps

module pva_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input pva_pkg::pva_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input pva_pkg::pva_out_t out_data_o
);
  import pva_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // one event in flight: no acceptance in the cycle right after one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted back-to-back events");

  a_non_attack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.start_attack |->
      (out_data_o.assigned_voice == 3'd0) && !out_data_o.was_stolen &&
      (out_data_o.out_note == 7'd0) && (out_data_o.out_velocity == 7'd0))
    else $error("voice fields set without attack");

endmodule

bind poly_voice_allocator pva_checker u_pva_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// File: bench/poly_voice_allocator_tb.sv
`timescale 1ns / 1ps

module poly_voice_allocator_tb;
  import pva_pkg::*;

  localparam int NUM_VOICES = 8;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_EVENTS = 1100;
  localparam int CALM_TAIL = 150;

  typedef struct packed {
    logic     pinned;
    pva_out_t want;
    pva_in_t  ev;
  } script_row_t;

  logic     clk_i;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  pva_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  pva_out_t out_data_o;

  // shadow voice table
  logic        voice_on    [NUM_VOICES];
  logic [6:0]  voice_note  [NUM_VOICES];
  logic [31:0] voice_stamp [NUM_VOICES];

  pva_out_t    pending_results [$];
  int unsigned mismatches = 0;
  bit          calm = 1'b0;
  logic [31:0] tick_count = '0;

  poly_voice_allocator #(
    .VOICES(NUM_VOICES)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic pva_in_t ev_of(logic [1:0] k, logic [6:0] n, logic [6:0] v,
                                    logic [2:0] vi, logic [31:0] t);
    pva_in_t ev;
    ev.kind        = k;
    ev.note        = n;
    ev.velocity    = v;
    ev.voice_index = vi;
    ev.now         = t;
    return ev;
  endfunction

  function automatic pva_out_t res_of(logic [2:0] voice, logic attack, logic stolen,
                                      logic [7:0] mask, logic [6:0] n, logic [6:0] v);
    pva_out_t res;
    res.assigned_voice = voice;
    res.start_attack   = attack;
    res.was_stolen     = stolen;
    res.release_mask   = mask;
    res.out_note       = n;
    res.out_velocity   = v;
    return res;
  endfunction

  function automatic pva_out_t allocate_event(pva_in_t ev);
    pva_out_t    res;
    logic        found_free;
    logic        found_busy;
    int          free_v;
    int          steal_v;
    int          chosen;
    logic [31:0] oldest;
    res        = '0;
    found_free = 1'b0;
    found_busy = 1'b0;
    free_v     = 0;
    steal_v    = 0;
    oldest     = '0;
    case (ev.kind)
      KIND_NOTE_ON: begin
        for (int i = 0; i < NUM_VOICES; i++) begin
          if (!voice_on[i]) begin
            found_free = 1'b1;
            free_v     = i;
          end else if (!found_busy || voice_stamp[i] < oldest) begin
            found_busy = 1'b1;
            oldest     = voice_stamp[i];
            steal_v    = i;
          end
        end
        chosen              = found_free ? free_v : steal_v;
        voice_on[chosen]    = 1'b1;
        voice_note[chosen]  = ev.note;
        voice_stamp[chosen] = ev.now;
        res.assigned_voice  = 3'(chosen);
        res.start_attack    = 1'b1;
        res.was_stolen      = !found_free;
        res.out_note        = ev.note;
        res.out_velocity    = ev.velocity;
      end
      KIND_NOTE_OFF: begin
        for (int i = 0; i < NUM_VOICES && i < 8; i++) begin
          if (voice_on[i] && voice_note[i] == ev.note) res.release_mask[i] = 1'b1;
        end
      end
      KIND_FINISHED: begin
        if (int'(ev.voice_index) < NUM_VOICES) voice_on[ev.voice_index] = 1'b0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // mostly a small note range and a slowly running clock, so note offs hit
  // and stamps tie now and then
  function automatic pva_in_t random_event();
    pva_in_t     ev;
    int unsigned roll;
    int unsigned pick;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, NUM_VOICES - 1);
    case ($urandom_range(0, 49))
      0: tick_count = $urandom;
      1: tick_count = 32'hFFFF_FFF8;
      default: tick_count = tick_count + $urandom_range(0, 4);
    endcase
    ev.now         = tick_count;
    ev.velocity    = 7'($urandom_range(0, 127));
    ev.voice_index = 3'(pick);
    ev.note        = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                 : 7'(48 + $urandom_range(0, 11));
    if (roll < 42) begin
      ev.kind = KIND_NOTE_ON;
    end else if (roll < 68) begin
      ev.kind = KIND_NOTE_OFF;
      if (voice_on[pick] && $urandom_range(0, 1) == 1) ev.note = voice_note[pick];
    end else if (roll < 95) begin
      ev.kind = KIND_FINISHED;
      if (!voice_on[pick]) ev.voice_index = 3'($urandom_range(0, NUM_VOICES - 1));
    end else begin
      ev.kind = KIND_UNUSED;
    end
    return ev;
  endfunction

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_result(pva_out_t got);
    pva_out_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result expected none actual %h", $time, got);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      compare_field("assigned_voice", 32'(want.assigned_voice), 32'(got.assigned_voice));
      compare_field("start_attack", 32'(want.start_attack), 32'(got.start_attack));
      compare_field("was_stolen", 32'(want.was_stolen), 32'(got.was_stolen));
      compare_field("release_mask", 32'(want.release_mask), 32'(got.release_mask));
      compare_field("out_note", 32'(want.out_note), 32'(got.out_note));
      compare_field("out_velocity", 32'(want.out_velocity), 32'(got.out_velocity));
    end
  endtask

  task automatic send_event(pva_in_t ev, logic pinned, pva_out_t want);
    pva_out_t predicted;
    in_valid_i <= 1'b1;
    in_data_i  <= ev;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = allocate_event(ev);
    pending_results.push_back(pinned ? want : predicted);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) check_result(out_data_o);
      if (calm) stall_left = 0;
      else if (stall_left == 0 && $urandom_range(0, 15) == 0)
        stall_left = $urandom_range(1, 12);
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin
    script_row_t directed [$];
    foreach (voice_on[i]) voice_on[i] = 1'b0;

    directed.push_back(script_row_t'{1'b1, res_of(3'd0, 1'b0, 1'b0, 8'h00, 7'd0, 7'd0),
                                     ev_of(KIND_NOTE_OFF, 7'd60, 7'd0, 3'd0, 32'd0)});
    directed.push_back(script_row_t'{1'b1, res_of(3'd0, 1'b0, 1'b0, 8'h00, 7'd0, 7'd0),
                                     ev_of(KIND_FINISHED, 7'd0, 7'd0, 3'd3, 32'd0)});
    directed.push_back(script_row_t'{1'b1, res_of(3'd0, 1'b0, 1'b0, 8'h00, 7'd0, 7'd0),
                                     ev_of(KIND_UNUSED, 7'd127, 7'd127, 3'd7, '1)});
    directed.push_back(script_row_t'{1'b1, res_of(3'd7, 1'b1, 1'b0, 8'h00, 7'd0, 7'd0),
                                     ev_of(KIND_NOTE_ON, 7'd0, 7'd0, 3'd0, 32'd0)});
    directed.push_back(script_row_t'{1'b1, res_of(3'd6, 1'b1, 1'b0, 8'h00, 7'd127, 7'd127),
                                     ev_of(KIND_NOTE_ON, 7'd127, 7'd127, 3'd7, '1)});
    directed.push_back(script_row_t'{1'b0, '0, ev_of(KIND_NOTE_ON, 7'd60, 7'd100, 3'd0, 32'd10)});
    directed.push_back(script_row_t'{1'b0, '0, ev_of(KIND_NOTE_ON, 7'd60, 7'd1, 3'd0, 32'd20)});
    directed.push_back(script_row_t'{1'b0, '0, ev_of(KIND_NOTE_ON, 7'd64, 7'd64, 3'd0, 32'd5)});
    directed.push_back(script_row_t'{1'b0, '0, ev_of(KIND_NOTE_ON, 7'd67, 7'd90, 3'd0, 32'd5)});
    directed.push_back(script_row_t'{1'b0, '0, ev_of(KIND_NOTE_ON, 7'd60, 7'd33, 3'd0, 32'd100)});
    directed.push_back(script_row_t'{1'b0, '0, ev_of(KIND_NOTE_ON, 7'd72, 7'd5, 3'd0, 32'd3)});
    // table full: steals, the last one on a stamp tie
    directed.push_back(script_row_t'{1'b0, '0, ev_of(KIND_NOTE_ON, 7'd61, 7'd10, 3'd0, 32'd50)});
    directed.push_back(script_row_t'{1'b0, '0, ev_of(KIND_NOTE_ON, 7'd62, 7'd20, 3'd0, 32'd7)});
    directed.push_back(script_row_t'{1'b0, '0, ev_of(KIND_NOTE_ON, 7'd63, 7'd30, 3'd0, 32'd8)});
    directed.push_back(script_row_t'{1'b0, '0, ev_of(KIND_NOTE_OFF, 7'd60, 7'd0, 3'd0, 32'd0)});
    directed.push_back(script_row_t'{1'b0, '0, ev_of(KIND_NOTE_OFF, 7'd127, 7'd0, 3'd0, 32'd0)});
    directed.push_back(script_row_t'{1'b0, '0, ev_of(KIND_NOTE_OFF, 7'd0, 7'd0, 3'd0, 32'd0)});
    directed.push_back(script_row_t'{1'b0, '0, ev_of(KIND_FINISHED, 7'd0, 7'd0, 3'd5, 32'd0)});
    directed.push_back(script_row_t'{1'b0, '0, ev_of(KIND_FINISHED, 7'd0, 7'd0, 3'd5, 32'd0)});
    directed.push_back(script_row_t'{1'b0, '0, ev_of(KIND_NOTE_OFF, 7'd60, 7'd0, 3'd0, 32'd0)});
    directed.push_back(script_row_t'{1'b0, '0, ev_of(KIND_NOTE_ON, 7'd60, 7'd127, 3'd0, 32'd200)});
    directed.push_back(script_row_t'{1'b0, '0, ev_of(KIND_FINISHED, 7'd0, 7'd0, 3'd0, 32'd0)});
    directed.push_back(script_row_t'{1'b0, '0, ev_of(KIND_FINISHED, 7'd0, 7'd0, 3'd7, 32'd0)});
    directed.push_back(script_row_t'{1'b0, '0, ev_of(KIND_NOTE_ON, 7'd0, 7'd0, 3'd0, 32'd0)});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_event(directed[i].ev, directed[i].pinned, directed[i].want);
    wait_for_results();

    for (int k = 0; k < RANDOM_EVENTS; k++) begin
      if (k == RANDOM_EVENTS / 2) wait_for_results();
      if (k == RANDOM_EVENTS - CALM_TAIL) calm = 1'b1;
      send_event(random_event(), 1'b0, '0);
    end
    wait_for_results();
    repeat (2 * NUM_VOICES + 4) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: poly_voice_allocator.f
sv/pva_pkg.sv
sv/pva_cmp.sv
sv/poly_voice_allocator.sv
sv/pva_checker.sv
bench/poly_voice_allocator_tb.sv
